/* src/lsjc_pkg.sv */
// ----------------------------------------------------------------------------
// lsjc_pkg
// Shared types, constants, error table and microcode ROM for the line
// steering junction counter.
// ----------------------------------------------------------------------------
`default_nettype none

package lsjc_pkg;

    // beat payloads
    typedef struct packed {
        logic        operation;
        logic [7:0]  sensor_byte;
        logic [31:0] time_ms;
    } sample_t;

    typedef struct packed {
        logic [15:0] left_speed;
        logic [15:0] right_speed;
        logic [7:0]  junction_count;
        logic        done_res;
        logic        line_lost;
    } result_t;

    typedef struct packed {
        logic [2:0]  reg_index;
        logic [15:0] wdata;
    } cfg_write_t;

    // register indexes
    localparam logic [2:0] CFG_TARGET_JUNCTIONS = 3'd0;
    localparam logic [2:0] CFG_PROP_GAIN        = 3'd1;
    localparam logic [2:0] CFG_DERIV_GAIN       = 3'd2;
    localparam logic [2:0] CFG_BASE_SPEED       = 3'd3;
    localparam logic [2:0] CFG_MAX_SPEED        = 3'd4;
    localparam logic [2:0] CFG_COOLDOWN_MS      = 3'd5;
    localparam logic [2:0] CFG_ALIGN_SPEED      = 3'd6;

    // register reset values
    localparam logic [7:0]  RST_TARGET_JUNCTIONS = 8'd1;
    localparam logic [15:0] RST_PROP_GAIN        = 16'd197;
    localparam logic [15:0] RST_DERIV_GAIN       = 16'd0;
    localparam logic [15:0] RST_BASE_SPEED       = 16'd9830;
    localparam logic [15:0] RST_MAX_SPEED        = 16'd26214;
    localparam logic [15:0] RST_COOLDOWN_MS      = 16'd500;
    localparam logic [15:0] RST_ALIGN_SPEED      = 16'd9830;

    typedef struct packed {
        logic [7:0]  target_junctions;
        logic [15:0] prop_gain;
        logic [15:0] deriv_gain;
        logic [15:0] base_speed;
        logic [15:0] max_speed;
        logic [15:0] cooldown_ms;
        logic [15:0] align_speed;
    } cfg_regs_t;

    // error of a lost line, Q5.8
    localparam logic signed [13:0] LOST_ERROR = 14'sd7680;

    // microcode
    typedef logic [3:0] step_t;

    typedef enum logic [3:0] {
        U_NOP,
        U_LOAD,
        U_CLASSIFY,
        U_ERR,
        U_MUL_P,
        U_MUL_D,
        U_ACC,
        U_TURN,
        U_SPEED,
        U_START,
        U_ALIGN,
        U_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_WAIT_IN,
        J_WAIT_OUT,
        J_BRANCH
    } jump_t;

    typedef struct packed {
        uop_t  uop;
        jump_t jump;
        step_t target;
    } ucode_t;

    // sequencer to datapath
    typedef struct packed {
        uop_t uop;
        logic en;
    } ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic is_start;
        logic finish;
        logic out_free;
    } status_t;

    localparam step_t STEP_WAIT_IN  = 4'd0;
    localparam step_t STEP_CLASSIFY = 4'd1;
    localparam step_t STEP_ERR      = 4'd2;
    localparam step_t STEP_MUL_P    = 4'd3;
    localparam step_t STEP_MUL_D    = 4'd4;
    localparam step_t STEP_ACC      = 4'd5;
    localparam step_t STEP_TURN     = 4'd6;
    localparam step_t STEP_SPEED    = 4'd7;
    localparam step_t STEP_START    = 4'd8;
    localparam step_t STEP_ALIGN    = 4'd9;
    localparam step_t STEP_EMIT     = 4'd10;

    // control program
    function automatic ucode_t ucode_rom(step_t pc);
        ucode_t uc;
        unique case (pc)
            STEP_WAIT_IN:  uc = '{U_LOAD,     J_WAIT_IN,  STEP_CLASSIFY};
            STEP_CLASSIFY: uc = '{U_CLASSIFY, J_BRANCH,   STEP_ERR};
            STEP_ERR:      uc = '{U_ERR,      J_NEXT,     STEP_MUL_P};
            STEP_MUL_P:    uc = '{U_MUL_P,    J_NEXT,     STEP_MUL_D};
            STEP_MUL_D:    uc = '{U_MUL_D,    J_NEXT,     STEP_ACC};
            STEP_ACC:      uc = '{U_ACC,      J_NEXT,     STEP_TURN};
            STEP_TURN:     uc = '{U_TURN,     J_NEXT,     STEP_SPEED};
            STEP_SPEED:    uc = '{U_SPEED,    J_GOTO,     STEP_EMIT};
            STEP_START:    uc = '{U_START,    J_GOTO,     STEP_EMIT};
            STEP_ALIGN:    uc = '{U_ALIGN,    J_GOTO,     STEP_EMIT};
            STEP_EMIT:     uc = '{U_EMIT,     J_WAIT_OUT, STEP_WAIT_IN};
            default:       uc = '{U_NOP,      J_GOTO,     STEP_WAIT_IN};
        endcase
        return uc;
    endfunction

    // rounded magnitude of 2560*mag/seen, ties away from zero
    function automatic logic [12:0] err_table(logic [1:0] mag, logic [2:0] seen);
        logic [12:0] v;
        unique case ({mag, seen})
            5'b01_001: v = 13'd2560;
            5'b01_010: v = 13'd1280;
            5'b01_011: v = 13'd853;
            5'b01_100: v = 13'd640;
            5'b01_101: v = 13'd512;
            5'b10_001: v = 13'd5120;
            5'b10_010: v = 13'd2560;
            5'b10_011: v = 13'd1707;
            5'b10_100: v = 13'd1280;
            5'b10_101: v = 13'd1024;
            5'b11_001: v = 13'd7680;
            5'b11_010: v = 13'd3840;
            5'b11_011: v = 13'd2560;
            5'b11_100: v = 13'd1920;
            5'b11_101: v = 13'd1536;
            default:   v = 13'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/lsjc_stream_if.sv */
// ----------------------------------------------------------------------------
// lsjc_stream_if
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsjc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/line_steering_junction_counter_core.sv */
// ----------------------------------------------------------------------------
// line_steering_junction_counter_core
// Steps: a steering sample runs classify, error, proportional multiply,
// derivative multiply, accumulate, turn, speed and emit through the shared
// multiplier; a start or done sample runs classify, start or align, and emit.
// A new sample is accepted only after emit, which stalls while the output is busy.
// Reset: rst_n clears count, cooldown, done and previous error, loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module line_steering_junction_counter_core
    import lsjc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    lsjc_stream_if.sink   sample,
    lsjc_stream_if.source result,
    lsjc_stream_if.sink   cfg
);

    cfg_regs_t regs;
    ctrl_t     ctrl;
    status_t   status;
    logic      in_ready;

    assign sample.ready = in_ready;

    // configuration registers
    lsjc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // microcode sequencer
    lsjc_sequencer u_sequencer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (in_ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    // datapath and output register
    lsjc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .sample_data (sample.data),
        .regs        (regs),
        .status      (status),
        .result      (result)
    );

endmodule

`default_nettype wire

/* src/lsjc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lsjc_cfg_regs
// Configuration register file, written through the cfg channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lsjc_cfg_regs
    import lsjc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    lsjc_stream_if.sink cfg,
    output cfg_regs_t   regs
);

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    // always able to take a write
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // register decode
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.data.reg_index)
                CFG_TARGET_JUNCTIONS: regs_next.target_junctions = cfg.data.wdata[7:0];
                CFG_PROP_GAIN:        regs_next.prop_gain        = cfg.data.wdata;
                CFG_DERIV_GAIN:       regs_next.deriv_gain       = cfg.data.wdata;
                CFG_BASE_SPEED:       regs_next.base_speed       = cfg.data.wdata;
                CFG_MAX_SPEED:        regs_next.max_speed        = cfg.data.wdata;
                CFG_COOLDOWN_MS:      regs_next.cooldown_ms      = cfg.data.wdata;
                CFG_ALIGN_SPEED:      regs_next.align_speed      = cfg.data.wdata;
                default:              regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.target_junctions <= RST_TARGET_JUNCTIONS;
            regs_reg.prop_gain        <= RST_PROP_GAIN;
            regs_reg.deriv_gain       <= RST_DERIV_GAIN;
            regs_reg.base_speed       <= RST_BASE_SPEED;
            regs_reg.max_speed        <= RST_MAX_SPEED;
            regs_reg.cooldown_ms      <= RST_COOLDOWN_MS;
            regs_reg.align_speed      <= RST_ALIGN_SPEED;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

/* src/lsjc_sequencer.sv */
// ----------------------------------------------------------------------------
// lsjc_sequencer
// Step counter over the microcode ROM with wait and branch conditions.
// ----------------------------------------------------------------------------
`default_nettype none

module lsjc_sequencer
    import lsjc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output ctrl_t        ctrl
);

    step_t  pc_reg;
    step_t  pc_next;
    ucode_t uc;

    assign uc = ucode_rom(pc_reg);

    // step enable and input handshake
    assign in_ready = (uc.jump == J_WAIT_IN);

    always_comb
    begin
        ctrl.uop = uc.uop;
        unique case (uc.jump)
            J_WAIT_IN:  ctrl.en = in_valid;
            J_WAIT_OUT: ctrl.en = status.out_free;
            default:    ctrl.en = 1'b1;
        endcase
    end

    // next step
    always_comb
    begin
        unique case (uc.jump)
            J_NEXT:     pc_next = pc_reg + step_t'(1);
            J_GOTO:     pc_next = uc.target;
            J_WAIT_IN:  pc_next = in_valid ? uc.target : pc_reg;
            J_WAIT_OUT: pc_next = status.out_free ? uc.target : pc_reg;
            J_BRANCH:
            begin
                priority if (status.is_start)
                    pc_next = STEP_START;
                else if (status.finish)
                    pc_next = STEP_ALIGN;
                else
                    pc_next = uc.target;
            end
            default:    pc_next = STEP_WAIT_IN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_WAIT_IN;
        else
            pc_reg <= pc_next;
    end

    // classification always leads to one of the three result paths
    a_branch_target: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == STEP_CLASSIFY |=>
            pc_reg == STEP_ERR || pc_reg == STEP_START || pc_reg == STEP_ALIGN)
        else $error("bad branch after classify");

    // the program counter stays inside the program
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= STEP_EMIT)
        else $error("step counter out of program");

    // a waiting emit holds its step
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == STEP_EMIT && !status.out_free |=> pc_reg == STEP_EMIT)
        else $error("emit left while output busy");

endmodule

`default_nettype wire

/* src/lsjc_datapath.sv */
// ----------------------------------------------------------------------------
// lsjc_datapath
// Junction counting state, error lookup, shared multiplier, clamp and
// output register, driven one micro-op per cycle; a waiting step holds its op.
// ----------------------------------------------------------------------------
`default_nettype none

module lsjc_datapath
    import lsjc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ctrl_t     ctrl,
    input  wire sample_t   sample_data,
    input  wire cfg_regs_t regs,
    output status_t        status,
    lsjc_stream_if.source  result
);

    // clamp to [0, max]
    function automatic logic [15:0] clamp_speed(logic signed [25:0] v, logic [15:0] max);
        logic [15:0] r;
        priority if (v < 26'sd0)
            r = 16'd0;
        else if (v > $signed({10'd0, max}))
            r = max;
        else
            r = v[15:0];
        return r;
    endfunction

    // payload registers
    sample_t                sample_reg;
    logic signed [13:0]     err_reg;
    logic signed [14:0]     diff_reg;
    logic signed [31:0]     prod_reg;
    logic signed [32:0]     acc_reg;
    logic signed [24:0]     turn_reg;
    result_t                res_reg;
    result_t                out_reg;

    // control state
    logic signed [13:0]     prev_reg;
    logic [7:0]             count_reg;
    logic [31:0]            stamp_reg;
    logic                   armed_reg;
    logic                   finished_reg;
    logic                   out_valid_reg;

    logic [4:0]             seen_bits;
    logic [2:0]             seen;
    logic                   lost;
    logic [1:0]             pos_w;
    logic [1:0]             neg_w;
    logic [1:0]             mag;
    logic                   neg;
    logic [12:0]            err_mag;
    logic signed [13:0]     err_seen;
    logic signed [13:0]     err_lost;
    logic                   junction;
    logic [31:0]            elapsed;
    logic                   take;
    logic [7:0]             count_inc;
    logic                   finish_pre;
    logic signed [16:0]     mul_a;
    logic signed [14:0]     mul_b;
    logic signed [31:0]     prod;
    logic signed [32:0]     rounded;
    logic signed [25:0]     sum_l;
    logic signed [25:0]     sum_r;

    // sensor decode, active low
    assign seen_bits = ~sample_reg.sensor_byte[4:0];
    assign seen      = 3'({2'b0, seen_bits[0]}) + 3'({2'b0, seen_bits[1]})
                     + 3'({2'b0, seen_bits[2]}) + 3'({2'b0, seen_bits[3]})
                     + 3'({2'b0, seen_bits[4]});
    assign lost      = (seen == 3'd0);

    // weighted error in tens: right minus left
    assign pos_w    = {seen_bits[4], seen_bits[3]};
    assign neg_w    = {seen_bits[0], seen_bits[1]};
    assign neg      = (neg_w > pos_w);
    assign mag      = neg ? (neg_w - pos_w) : (pos_w - neg_w);
    assign err_mag  = err_table(mag, seen);
    assign err_seen = neg ? -$signed({1'b0, err_mag}) : $signed({1'b0, err_mag});
    assign err_lost = (prev_reg < 14'sd0) ? -LOST_ERROR :
                      ((prev_reg != 14'sd0) ? LOST_ERROR : 14'sd0);

    // junction and cooldown
    assign junction   = (seen_bits[0] && seen_bits[4])
                     || (seen_bits[0] && seen_bits[1] && seen_bits[2])
                     || (seen_bits[4] && seen_bits[3] && seen_bits[2]);
    assign elapsed    = sample_reg.time_ms - stamp_reg;
    assign finish_pre = finished_reg || (count_reg >= regs.target_junctions);
    assign take       = !finish_pre && junction
                     && (!armed_reg || (elapsed > {16'd0, regs.cooldown_ms}));
    assign count_inc  = count_reg + 8'd1;

    assign status.is_start = sample_reg.operation;
    assign status.finish   = finish_pre || (take && (count_inc >= regs.target_junctions));
    assign status.out_free = !out_valid_reg || result.ready;

    // shared multiplier
    assign mul_a   = $signed({1'b0, (ctrl.uop == U_MUL_P) ? regs.prop_gain : regs.deriv_gain});
    assign mul_b   = (ctrl.uop == U_MUL_P) ? {err_reg[13], err_reg} : diff_reg;
    assign prod    = mul_a * mul_b;

    // rounding shift and wheel sums
    assign rounded = acc_reg + 33'sd128;
    assign sum_l   = $signed({10'd0, regs.base_speed}) + {turn_reg[24], turn_reg};
    assign sum_r   = $signed({10'd0, regs.base_speed}) - {turn_reg[24], turn_reg};

    // output channel
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            count_reg     <= '0;
            stamp_reg     <= '0;
            armed_reg     <= 1'b0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.uop == U_CLASSIFY && !sample_reg.operation)
            begin
                if (finish_pre)
                    finished_reg <= 1'b1;
                else if (take)
                begin
                    count_reg <= count_inc;
                    stamp_reg <= sample_reg.time_ms;
                    armed_reg <= 1'b1;
                    if (count_inc >= regs.target_junctions)
                        finished_reg <= 1'b1;
                end
            end
            if (ctrl.uop == U_START)
            begin
                count_reg    <= '0;
                stamp_reg    <= '0;
                armed_reg    <= 1'b0;
                finished_reg <= 1'b0;
            end
            if (ctrl.uop == U_ERR && !lost)
                prev_reg <= err_seen;
            if (ctrl.uop == U_EMIT && ctrl.en)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (ctrl.uop)
            U_LOAD:
            begin
                if (ctrl.en)
                    sample_reg <= sample_data;
            end
            U_ERR:
            begin
                if (lost)
                begin
                    err_reg  <= err_lost;
                    diff_reg <= {err_lost[13], err_lost} - {prev_reg[13], prev_reg};
                end
                else
                begin
                    err_reg  <= err_seen;
                    diff_reg <= '0;
                end
            end
            U_MUL_P:
                prod_reg <= prod;
            U_MUL_D:
            begin
                acc_reg  <= {prod_reg[31], prod_reg};
                prod_reg <= prod;
            end
            U_ACC:
                acc_reg <= acc_reg + {prod_reg[31], prod_reg};
            U_TURN:
                turn_reg <= rounded[32:8];
            U_SPEED:
            begin
                res_reg.left_speed     <= clamp_speed(sum_l, regs.max_speed);
                res_reg.right_speed    <= clamp_speed(sum_r, regs.max_speed);
                res_reg.junction_count <= count_reg;
                res_reg.done_res       <= 1'b0;
                res_reg.line_lost      <= lost;
            end
            U_START:
                res_reg <= '0;
            U_ALIGN:
            begin
                res_reg.left_speed     <= regs.align_speed;
                res_reg.right_speed    <= regs.align_speed;
                res_reg.junction_count <= count_reg;
                res_reg.done_res       <= 1'b1;
                res_reg.line_lost      <= lost;
            end
            U_EMIT:
            begin
                if (ctrl.en)
                    out_reg <= res_reg;
            end
            default:
            begin
            end
        endcase
    end

    // count only steps by one or restarts at zero
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            count_reg == $past(count_reg) + 8'd1 || count_reg == 8'd0)
        else $error("junction count jumped");

    // stored error stays within the lost-line bound
    a_prev_range: assert property (@(posedge clk) disable iff (!rst_n)
        prev_reg <= LOST_ERROR && prev_reg >= -LOST_ERROR)
        else $error("previous error out of range");

    // with the line seen the derivative input is zero
    a_diff_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.uop == U_ERR && !lost |=> diff_reg == 15'sd0)
        else $error("derivative active on seen line");

    // a done beat drives both wheels alike
    a_done_equal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.done_res |-> out_reg.left_speed == out_reg.right_speed)
        else $error("done beat with unequal wheels");

endmodule

`default_nettype wire
